FILE: hw/rtl/mpu_pkg.sv
// ----------------------------------------------------------------------------
// mpu_pkg
// Shared types, widths and helpers for the periodic unwrap block.
// ----------------------------------------------------------------------------
package mpu_pkg;

  // coordinate and box widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned BOX_W   = 31;
  // shift store width: a total shift spans up to +-2^32
  localparam int unsigned SHIFT_W = 34;
  // datapath width of the shared adder
  localparam int unsigned ACC_W   = 36;

  // configuration register indexes
  localparam logic [1:0] CFG_CELL_X = 2'd0;
  localparam logic [1:0] CFG_CELL_Y = 2'd1;
  localparam logic [1:0] CFG_CELL_Z = 2'd2;

  // box length after reset, 1.0 in unsigned Q15.16
  localparam logic [BOX_W-1:0] BOX_RESET = 31'd65536;

  localparam logic signed [ACC_W-1:0] SAT_HI = 36'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_LO = -36'sd2147483648;

  typedef struct packed {
    logic                     starts_molecule;
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic signed [COORD_W-1:0] z_in;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic signed [COORD_W-1:0] z_out;
    logic                     wrap_overflow;
  } out_item_t;

  // request to the shared add / compare unit
  typedef struct packed {
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic                    sub;
    logic signed [ACC_W-1:0] cmp;
  } alu_req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic                    above;
    logic                    below;
  } alu_rsp_t;

  // clamp a datapath value to the signed 32 bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[COORD_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/mpu_stream_if.sv
// ----------------------------------------------------------------------------
// mpu_stream_if
// Valid / ready stream carrying one item per handshake.
// ----------------------------------------------------------------------------
interface mpu_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/mpu_alu.sv
// ----------------------------------------------------------------------------
// mpu_alu
// Shared add/subtract unit with the half-box window compare.
// ----------------------------------------------------------------------------
module mpu_alu import mpu_pkg::*; (
  input  alu_req_t          req_i,
  input  logic [BOX_W-1:0]  box_i,
  output alu_rsp_t          rsp_o
);

  logic signed [ACC_W-1:0] box_s;
  logic signed [ACC_W-1:0] dbl;

  // one wide adder
  assign rsp_o.sum = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);

  // exact half-box test: 2*v against +-box
  assign box_s       = signed'({{(ACC_W-BOX_W){1'b0}}, box_i});
  assign dbl         = req_i.cmp <<< 1;
  assign rsp_o.above = dbl > box_s;
  assign rsp_o.below = dbl < -box_s;

endmodule

FILE: hw/rtl/molecule_periodic_unwrap.sv
// ----------------------------------------------------------------------------
// molecule_periodic_unwrap
// Minimum-image unwrap of atoms into the reference atom's centred box.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_i      in   valid/ready   starts_molecule, x_in, y_in, z_in
//  out_o     out  valid/ready   x_out, y_out, z_out, wrap_overflow
//  cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i (box lengths)
//
//  axes are handled one after another by a single shared adder/compare unit
//  later atom: each axis passes LOAD, WRAP, FINISH, between accept (IDLE) and DONE
//  reference atom: WRAP repeats once per wrap step, k = wrap steps (0..MAX_WRAPS)
//  a result sits in the output register; the next item may be taken while it
//  waits, but the following result stalls until that register is free
//  reset clears state, references, shifts and box lengths (1.0 each)
// ----------------------------------------------------------------------------
module molecule_periodic_unwrap import mpu_pkg::*; #(
  parameter int unsigned MAX_WRAPS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [BOX_W-1:0]   cfg_data_i,
  mpu_stream_if.sink         in_i,
  mpu_stream_if.source       out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_WRAPS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_WRAP   = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]               state_q, state_d;
  logic [1:0]               axis_q, axis_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     ovf_q, ovf_d;
  logic                     out_valid_q, out_valid_d;
  logic [BOX_W-1:0]         box_q [3];
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  in_item_t                 item_q;
  logic signed [COORD_W-1:0] ref_q [3];
  logic signed [SHIFT_W-1:0] shift_q [3];
  logic signed [COORD_W-1:0] res_q [3];
  out_item_t                out_q;

  logic                     in_acc;
  logic                     out_free;
  logic signed [COORD_W-1:0] raw;
  logic signed [ACC_W-1:0]  raw_ext;
  logic signed [ACC_W-1:0]  ref_ext;
  logic signed [ACC_W-1:0]  shift_ext;
  logic signed [ACC_W-1:0]  box_ext;
  logic                     outside;
  logic                     can_step;
  alu_req_t                 req;
  alu_rsp_t                 rsp;

  // handshake
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // operands of the current axis
  always_comb begin
    case (axis_q)
      2'd0:    raw = item_q.x_in;
      2'd1:    raw = item_q.y_in;
      default: raw = item_q.z_in;
    endcase
  end

  assign raw_ext   = ACC_W'(raw);
  assign ref_ext   = ACC_W'(ref_q[axis_q]);
  assign shift_ext = ACC_W'(shift_q[axis_q]);
  assign box_ext   = signed'({{(ACC_W-BOX_W){1'b0}}, box_q[axis_q]});
  assign outside   = rsp.above || rsp.below;
  assign can_step  = outside && (cnt_q < CNT_W'(MAX_WRAPS));

  mpu_alu u_alu (
    .req_i (req),
    .box_i (box_q[axis_q]),
    .rsp_o (rsp)
  );

  // sequencer and shared unit operand selection
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_o.ready;
    req.a       = acc_q;
    req.b       = box_ext;
    req.sub     = 1'b0;
    req.cmp     = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_LOAD;
          axis_d  = 2'd0;
          if (in_i.data.starts_molecule) begin
            ovf_d = 1'b0;
          end
        end
      end
      ST_LOAD: begin
        // reference: pos = raw, later atom: d = raw - ref
        req.a   = raw_ext;
        req.b   = item_q.starts_molecule ? '0 : ref_ext;
        req.sub = 1'b1;
        acc_d   = rsp.sum;
        cnt_d   = '0;
        state_d = ST_WRAP;
      end
      ST_WRAP: begin
        if (item_q.starts_molecule) begin
          // one wrap step per cycle toward the centred box
          req.sub = rsp.above;
          if (can_step) begin
            acc_d = rsp.sum;
            cnt_d = cnt_q + 1'b1;
          end else begin
            if (outside) begin
              ovf_d = 1'b1;
            end
            state_d = ST_FINISH;
          end
        end else begin
          // minimum image: move one box when strictly closer
          req.a   = raw_ext;
          req.b   = outside ? box_ext : '0;
          req.sub = rsp.above;
          acc_d   = rsp.sum;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (item_q.starts_molecule) begin
          // shift = pos - raw
          req.b   = raw_ext;
          req.sub = 1'b1;
        end else begin
          req.b   = shift_ext;
          req.sub = 1'b0;
        end
        if (axis_q == 2'd2) begin
          state_d = ST_DONE;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = ST_LOAD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 2'd0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // box lengths, molecule reference and shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_q[i]   <= BOX_RESET;
        ref_q[i]   <= '0;
        shift_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CELL_X: box_q[0] <= cfg_data_i;
          CFG_CELL_Y: box_q[1] <= cfg_data_i;
          CFG_CELL_Z: box_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_FINISH && item_q.starts_molecule) begin
        ref_q[axis_q]   <= raw;
        shift_q[axis_q] <= rsp.sum[SHIFT_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_acc) begin
      item_q <= in_i.data;
    end
    if (state_q == ST_FINISH) begin
      res_q[axis_q] <= item_q.starts_molecule ? sat32(acc_q) : sat32(rsp.sum);
    end
    if (state_q == ST_DONE && out_free) begin
      out_q.x_out         <= res_q[0];
      out_q.y_out         <= res_q[1];
      out_q.z_out         <= res_q[2];
      out_q.wrap_overflow <= ovf_q;
    end
  end

  // checks
  a_accept_starts_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_LOAD && axis_q == 2'd0))
    else $error("item accepted but sequencer did not start on x");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside the completion state");

  a_later_one_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRAP && !item_q.starts_molecule) |=> state_q == ST_FINISH)
    else $error("later atom took more than one image step");

  a_wrap_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRAP |-> cnt_q <= CNT_W'(MAX_WRAPS))
    else $error("wrap step count passed the limit");

endmodule

FILE: tb/molecule_periodic_unwrap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// molecule_periodic_unwrap_tb
// Self-checking bench for the periodic unwrap block. Atoms go in through the
// input stream, a behavioral copy of the unwrap math predicts every result,
// and the output stream is compared field by field in arrival order. Box
// lengths are changed only while the block is drained.
// ----------------------------------------------------------------------------
module molecule_periodic_unwrap_tb;
  import mpu_pkg::*;

  localparam int unsigned WRAP_LIMIT = 8;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic [BOX_W-1:0] BOX_MAX = 31'h7FFF_FFFF;
  localparam logic [BOX_W-1:0] BOX_ONE = 31'd65536;
  localparam longint HALF = 64'sd32768;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [BOX_W-1:0] cfg_data_i;

  mpu_stream_if #(.item_t(in_item_t))  atom_in ();
  mpu_stream_if #(.item_t(out_item_t)) atom_out ();

  molecule_periodic_unwrap #(
    .MAX_WRAPS(WRAP_LIMIT)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (atom_in),
    .out_o     (atom_out)
  );

  // predictor state: box lengths, current molecule's reference and shift
  longint box_len [3];
  longint ref_pos [3];
  longint tot_shift [3];
  bit ovf_seen;

  // results still owed by the block, oldest first
  out_item_t pending_atoms [$];

  // run bookkeeping
  bit steady;
  int unsigned errors;
  int unsigned n_atoms;
  int unsigned n_molecules;
  int unsigned n_results;
  int unsigned n_overflow;
  int unsigned n_box_settings;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("molecule_periodic_unwrap_tb NOT OK");
    $finish;
  end

  // clamp to the signed 32 bit range
  function automatic logic signed [COORD_W-1:0] to_q16(input longint v);
    if (v > Q_MAX) begin
      v = Q_MAX;
    end else if (v < Q_MIN) begin
      v = Q_MIN;
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // random box length between two bounds
  function automatic logic [BOX_W-1:0] rand_box(input int unsigned lo, input int unsigned hi);
    return BOX_W'($urandom_range(hi, lo));
  endfunction

  // expected result for one atom, updates the molecule state
  function automatic out_item_t unwrap_atom(input in_item_t atom);
    out_item_t res;
    logic signed [COORD_W-1:0] coord_in [3];
    logic signed [COORD_W-1:0] coord_out [3];
    longint raw, box, pos, shift, delta, best, moved;
    int steps;
    int a;
    coord_in[0] = atom.x_in;
    coord_in[1] = atom.y_in;
    coord_in[2] = atom.z_in;
    if (atom.starts_molecule) begin
      ovf_seen = 1'b0;
    end
    for (a = 0; a < 3; a++) begin
      raw = longint'(coord_in[a]);
      box = box_len[a];
      if (atom.starts_molecule) begin
        // wrap the reference into the centred box, bounded step count
        pos = raw;
        shift = 0;
        steps = 0;
        while (steps < WRAP_LIMIT && (2 * pos > box || 2 * pos < -box)) begin
          if (2 * pos > box) begin
            pos -= box;
            shift -= box;
          end else begin
            pos += box;
            shift += box;
          end
          steps++;
        end
        if (2 * pos > box || 2 * pos < -box) begin
          ovf_seen = 1'b1;
        end
        ref_pos[a] = raw;
        tot_shift[a] = shift;
        coord_out[a] = to_q16(pos);
      end else begin
        // minimum image against the raw reference, then the molecule shift
        delta = raw - ref_pos[a];
        best = mag(delta);
        moved = raw;
        if (mag(delta - box) < best) begin
          moved = raw - box;
        end
        if (mag(delta + box) < best) begin
          moved = raw + box;
        end
        coord_out[a] = to_q16(moved + tot_shift[a]);
      end
    end
    res.x_out = coord_out[0];
    res.y_out = coord_out[1];
    res.z_out = coord_out[2];
    res.wrap_overflow = ovf_seen;
    return res;
  endfunction

  function automatic in_item_t mk_atom(input bit start, input longint x, input longint y,
                                       input longint z);
    in_item_t atom;
    atom.starts_molecule = start;
    atom.x_in = to_q16(x);
    atom.y_in = to_q16(y);
    atom.z_in = to_q16(z);
    return atom;
  endfunction

  // random coordinate within +-span of center
  function automatic logic signed [COORD_W-1:0] near_coord(input longint center,
                                                           input longint span);
    longint unsigned r;
    longint unsigned width;
    if (span < 1) begin
      span = 1;
    end
    r = {$urandom(), $urandom()};
    width = longint'(2 * span + 1);
    return to_q16(center + longint'(r % width) - span);
  endfunction

  // send one item, idling at random before it outside the steady phase
  task automatic send_atom(input in_item_t atom);
    while (!steady && $urandom_range(0, 99) < 14) begin
      atom_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    atom_in.valid <= 1'b1;
    atom_in.data <= atom;
    do @(posedge clk_i); while (!atom_in.ready);
    pending_atoms.push_back(unwrap_atom(atom));
    n_atoms++;
    if (atom.starts_molecule) begin
      n_molecules++;
    end
  endtask

  // hold the sender until every owed result has come back
  task automatic wait_results_done();
    atom_in.valid <= 1'b0;
    while (pending_atoms.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // write all three box lengths, block must be drained
  task automatic set_boxes(input logic [BOX_W-1:0] bx, input logic [BOX_W-1:0] by,
                           input logic [BOX_W-1:0] bz);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_CELL_X;
    cfg_data_i <= bx;
    @(posedge clk_i);
    cfg_idx_i <= CFG_CELL_Y;
    cfg_data_i <= by;
    @(posedge clk_i);
    cfg_idx_i <= CFG_CELL_Z;
    cfg_data_i <= bz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    box_len[0] = longint'(bx);
    box_len[1] = longint'(by);
    box_len[2] = longint'(bz);
    n_box_settings++;
  endtask

  // random molecules: mostly well formed, some noise items
  task automatic run_molecules(input int n);
    int sent;
    int len;
    int i;
    int a;
    int k;
    bit noise;
    longint mol_ref [3];
    logic signed [COORD_W-1:0] c [3];
    in_item_t atom;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 6);
      noise = ($urandom_range(0, 99) < 10);
      for (i = 0; i < len && sent < n; i++) begin
        if (noise) begin
          atom.starts_molecule = 1'($urandom_range(0, 1));
          for (a = 0; a < 3; a++) begin
            c[a] = $urandom();
          end
        end else if (i == 0) begin
          atom.starts_molecule = 1'b1;
          for (a = 0; a < 3; a++) begin
            // up to nine boxes out, so the wrap limit is hit now and then
            k = $urandom_range(0, 9);
            c[a] = near_coord(0, k * box_len[a] + box_len[a] / 2);
            mol_ref[a] = longint'(c[a]);
          end
        end else begin
          atom.starts_molecule = 1'b0;
          for (a = 0; a < 3; a++) begin
            c[a] = near_coord(mol_ref[a], box_len[a] + box_len[a] / 2);
          end
        end
        atom.x_in = c[0];
        atom.y_in = c[1];
        atom.z_in = c[2];
        send_atom(atom);
        sent++;
      end
    end
  endtask

  // default boxes: atoms before any molecule start, half-box edges
  task automatic test_reset_state();
    send_atom(mk_atom(1'b0, 0, 0, 0));
    send_atom(mk_atom(1'b0, Q_MAX, Q_MIN, 40000));
    send_atom(mk_atom(1'b1, HALF, -HALF, 0));
    send_atom(mk_atom(1'b0, 2 * HALF, -2 * HALF, HALF));
    send_atom(mk_atom(1'b0, 2 * HALF + 1, -2 * HALF - 1, -HALF - 1));
    send_atom(mk_atom(1'b1, HALF + 1, -HALF - 1, 3 * HALF));
    send_atom(mk_atom(1'b0, 3 * HALF + 1, -3 * HALF - 2, 0));
  endtask

  // reference needing exactly the step limit, and one step more
  task automatic test_wrap_limit();
    send_atom(mk_atom(1'b1, 17 * HALF, 17 * HALF + 1, 0));
    send_atom(mk_atom(1'b0, 17 * HALF, 17 * HALF + 5, 5));
    send_atom(mk_atom(1'b1, 0, 0, 0));
    send_atom(mk_atom(1'b1, 0, 0, -17 * HALF - 1));
    send_atom(mk_atom(1'b0, 7, -7, -17 * HALF));
  endtask

  // largest, smallest, mixed and zero box lengths, output clamping
  task automatic test_box_extremes();
    wait_results_done();
    set_boxes(BOX_MAX, BOX_MAX, BOX_MAX);
    send_atom(mk_atom(1'b1, Q_MAX, Q_MIN, 0));
    send_atom(mk_atom(1'b0, Q_MIN, Q_MAX, Q_MAX));
    send_atom(mk_atom(1'b1, Q_MIN, Q_MAX, Q_MIN));
    send_atom(mk_atom(1'b0, Q_MAX, Q_MIN, 1));
    wait_results_done();
    set_boxes(31'd1, 31'd1, 31'd1);
    send_atom(mk_atom(1'b1, Q_MIN, Q_MAX, 1));
    send_atom(mk_atom(1'b0, Q_MAX, Q_MIN, 0));
    send_atom(mk_atom(1'b1, 0, 1, -1));
    wait_results_done();
    set_boxes(31'd1, BOX_MAX, BOX_ONE);
    send_atom(mk_atom(1'b1, 3, Q_MIN, 5 * HALF));
    send_atom(mk_atom(1'b0, -3, Q_MAX, -5 * HALF));
    wait_results_done();
    set_boxes('0, '0, '0);
    send_atom(mk_atom(1'b1, 5, 0, 0));
    send_atom(mk_atom(1'b0, 100, -100, 0));
    send_atom(mk_atom(1'b1, 0, 0, 0));
  endtask

  // typical boxes with no stalls on either side
  task automatic test_typical_box();
    wait_results_done();
    set_boxes(rand_box(655360, 6553600), rand_box(655360, 6553600),
              rand_box(655360, 6553600));
    steady = 1'b1;
    run_molecules(190);
    steady = 1'b0;
  endtask

  // sender holds off until the block is empty, then resumes
  task automatic test_pause_drain();
    wait_results_done();
    set_boxes(rand_box(655360, 6553600), rand_box(655360, 6553600),
              rand_box(655360, 6553600));
    run_molecules(95);
    wait_results_done();
    run_molecules(95);
  endtask

  // tiny boxes, wrap limit frequently reached
  task automatic test_small_box();
    wait_results_done();
    set_boxes(rand_box(1, 1024), rand_box(1, 1024), rand_box(1, 1024));
    run_molecules(190);
  endtask

  // boxes near the top of the register range
  task automatic test_large_box();
    wait_results_done();
    set_boxes(BOX_MAX, rand_box(32'h4000_0000, 32'h7FFF_FFFF),
              rand_box(32'h4000_0000, 32'h7FFF_FFFF));
    run_molecules(190);
  endtask

  // box lengths anywhere in range, a fresh setting per round
  task automatic test_random_box();
    int r;
    for (r = 0; r < 2; r++) begin
      wait_results_done();
      set_boxes(rand_box(1, 32'h7FFF_FFFF), rand_box(1, 32'h7FFF_FFFF),
                rand_box(1, 32'h7FFF_FFFF));
      run_molecules(95);
    end
    wait_results_done();
    set_boxes(rand_box(655360, 6553600), rand_box(1, 1024),
              rand_box(32'h4000_0000, 32'h7FFF_FFFF));
    run_molecules(190);
  endtask

  // receiver stalls at random except in the steady phase
  always @(posedge clk_i) begin
    atom_out.ready <= steady || ($urandom_range(0, 99) >= 14);
  end

  // compare each result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && atom_out.valid && atom_out.ready) begin
      n_results++;
      if (pending_atoms.size() == 0) begin
        $error("result with no atom pending: x %0d y %0d z %0d ovf %0b",
               atom_out.data.x_out, atom_out.data.y_out, atom_out.data.z_out,
               atom_out.data.wrap_overflow);
        errors++;
      end else begin
        want = pending_atoms.pop_front();
        if (want.wrap_overflow) begin
          n_overflow++;
        end
        if (atom_out.data.x_out !== want.x_out) begin
          $error("x_out mismatch: expected %0d, got %0d", want.x_out, atom_out.data.x_out);
          errors++;
        end
        if (atom_out.data.y_out !== want.y_out) begin
          $error("y_out mismatch: expected %0d, got %0d", want.y_out, atom_out.data.y_out);
          errors++;
        end
        if (atom_out.data.z_out !== want.z_out) begin
          $error("z_out mismatch: expected %0d, got %0d", want.z_out, atom_out.data.z_out);
          errors++;
        end
        if (atom_out.data.wrap_overflow !== want.wrap_overflow) begin
          $error("wrap_overflow mismatch: expected %0b, got %0b", want.wrap_overflow,
                 atom_out.data.wrap_overflow);
          errors++;
        end
      end
    end
  end

  // sequence of tests
  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_CELL_X;
    cfg_data_i <= '0;
    atom_in.valid <= 1'b0;
    atom_in.data <= '0;
    steady = 1'b0;
    errors = 0;
    n_atoms = 0;
    n_molecules = 0;
    n_results = 0;
    n_overflow = 0;
    n_box_settings = 0;
    box_len[0] = longint'(BOX_ONE);
    box_len[1] = longint'(BOX_ONE);
    box_len[2] = longint'(BOX_ONE);
    for (int a = 0; a < 3; a++) begin
      ref_pos[a] = 0;
      tot_shift[a] = 0;
    end
    ovf_seen = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_wrap_limit();
    test_box_extremes();
    test_typical_box();
    test_pause_drain();
    test_small_box();
    test_large_box();
    test_random_box();

    // drain, then allow for a stray late result
    wait_results_done();
    repeat (64) @(posedge clk_i);
    $display("checked %0d results for %0d atoms in %0d molecules, %0d with wrap overflow",
             n_results, n_atoms, n_molecules, n_overflow);
    $display("%0d box settings from zero and one to full range, random stalls both sides",
             n_box_settings);
    if (errors == 0 && pending_atoms.size() == 0) begin
      $display("molecule_periodic_unwrap_tb OK");
    end else begin
      $display("molecule_periodic_unwrap_tb NOT OK");
    end
    $finish;
  end

endmodule
